@@ src/sbcd_pkg.sv @@
// Shared types and constants for the stereo bitcrusher and decimator.
package sbcd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t POS_MAX = sample_t'((1 << (SAMPLE_W - 1)) - 1);
    localparam sample_t NEG_MIN = sample_t'(1 << (SAMPLE_W - 1));

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BIT_DEPTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIM         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_AMOUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_AMOUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd4;

    // Register values after reset.
    localparam logic [4:0]  RST_BIT_DEPTH     = 5'd8;
    localparam logic [6:0]  RST_DECIM         = 7'd8;
    localparam logic [8:0]  RST_JITTER_AMOUNT = 9'd0;
    localparam logic [8:0]  RST_MIX_AMOUNT    = 9'd256;
    localparam logic [14:0] RST_OUTPUT_GAIN   = 15'd4096;

    localparam logic [31:0] RNG_SEED = 32'd2463534242;

    // Register values after range limiting.
    typedef struct packed {
        logic [4:0]  depth;
        logic [6:0]  rd;
        logic [8:0]  jit;
        logic [8:0]  mix;
        logic [14:0] gain;
    } cfg_t;

    // One frame as it waits between the front and the back.
    typedef struct packed {
        sample_t dry_l;
        sample_t dry_r;
        sample_t wet_l;
        sample_t wet_r;
        logic    blk;
    } frame_t;

endpackage

@@ src/sbcd_front.sv @@
// Front end: accepts frames and quantizes both channels before they are queued.
module sbcd_front (
    input  sbcd_pkg::sample_t left_in,
    input  sbcd_pkg::sample_t right_in,
    input  logic              block_end,
    input  logic              frame_valid,
    output logic              frame_stall,
    input  logic [4:0]        depth,
    input  logic              q_full,
    output logic              q_push,
    output sbcd_pkg::frame_t  q_wr_data
);
    import sbcd_pkg::*;

    localparam int MAG_W = SAMPLE_W + 1;
    localparam int SH_W  = $clog2(SAMPLE_W);

    // Rounds the magnitude to a multiple of the step, halves away from zero.
    function automatic sample_t quantize(input sample_t x, input logic [4:0] d);
        logic [SH_W-1:0]  sh;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] half;
        logic [MAG_W-1:0] keep;
        logic [MAG_W-1:0] r;
        sample_t          y;
        sh   = SH_W'(5'(SAMPLE_W) - d);
        neg  = x[SAMPLE_W-1];
        mag  = neg ? (MAG_W'(0) - MAG_W'(x)) : MAG_W'(x);
        half = MAG_W'(1) << (sh - SH_W'(1));
        keep = ~((MAG_W'(1) << sh) - MAG_W'(1));
        r    = (mag + half) & keep;
        if (d >= 5'(SAMPLE_W))
        begin
            y = x;
        end
        else if (!neg)
        begin
            y = (r > MAG_W'(POS_MAX)) ? POS_MAX : sample_t'(r);
        end
        else
        begin
            y = (r > (MAG_W'(1) << (SAMPLE_W - 1))) ? NEG_MIN
                                                     : sample_t'(MAG_W'(0) - r);
        end
        return y;
    endfunction

    assign frame_stall = q_full;
    assign q_push      = frame_valid && !q_full;

    always_comb
    begin
        q_wr_data.dry_l = left_in;
        q_wr_data.dry_r = right_in;
        q_wr_data.wet_l = quantize(left_in, depth);
        q_wr_data.wet_r = quantize(right_in, depth);
        q_wr_data.blk   = block_end;
    end

endmodule

@@ src/sbcd_queue.sv @@
// Two-entry frame queue between the front end and the back end.
module sbcd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sbcd_pkg::frame_t wr_data,
    output logic             full,
    output logic             q_valid,
    input  logic             pop,
    output sbcd_pkg::frame_t rd_data
);
    import sbcd_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ src/sbcd_back.sv @@
// Back end: hold counter, jitter draw with serial remainder, mix and gain, result register.
module sbcd_back #(
    parameter int MAX_DECIM = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sbcd_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  sbcd_pkg::frame_t  q_rd_data,
    output logic              q_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output sbcd_pkg::sample_t left_out,
    output sbcd_pkg::sample_t right_out,
    output logic              block_end_out
);
    import sbcd_pkg::*;

    // The decimation register is 7 bits wide, so the usable limit never exceeds 127.
    localparam int RD_MAX   = (MAX_DECIM > 127) ? 127 : MAX_DECIM;
    localparam int JM_MAX   = RD_MAX / 2;
    localparam int HOLD_MAX = RD_MAX + JM_MAX;
    localparam int HOLD_W   = $clog2(HOLD_MAX + 1);
    localparam int SUM_W    = HOLD_W + 1;
    localparam int JM_W     = $clog2(JM_MAX + 1);
    localparam int DIV_W    = $clog2(2 * JM_MAX + 2);
    localparam int DVD_W    = 32;
    localparam int CNT_W    = $clog2(DVD_W + 1);
    localparam int ACC_W    = 25;
    localparam int MB_W     = 17;
    localparam int PROD_W   = 41;
    localparam int MUL_W    = ACC_W + MB_W;
    localparam int Q_W      = PROD_W - 20;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_L1   = 3'd1;
    localparam logic [2:0] ST_L2   = 3'd2;
    localparam logic [2:0] ST_L3   = 3'd3;
    localparam logic [2:0] ST_R1   = 3'd4;
    localparam logic [2:0] ST_R2   = 3'd5;
    localparam logic [2:0] ST_R3   = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    // Shift right by 20 with rounding half away from zero, then saturate.
    function automatic sample_t round_sat(input logic signed [PROD_W-1:0] p);
        logic               neg;
        logic [PROD_W-1:0]  mag;
        logic [Q_W-1:0]     q;
        sample_t            y;
        neg = p[PROD_W-1];
        mag = neg ? (PROD_W'(0) - p) : p;
        q   = Q_W'((mag + (PROD_W'(1) << 19)) >> 20);
        if (!neg)
        begin
            y = (q > Q_W'(POS_MAX)) ? POS_MAX : sample_t'(q);
        end
        else
        begin
            y = (q > (Q_W'(1) << (SAMPLE_W - 1))) ? NEG_MIN : sample_t'(Q_W'(0) - q);
        end
        return y;
    endfunction

    logic [2:0]               state_reg, state_next;
    logic [HOLD_W-1:0]        hold_reg;
    logic [31:0]              rng_reg;
    logic                     div_busy_reg;
    logic [CNT_W-1:0]         div_cnt_reg;
    logic [DVD_W-1:0]         dvd_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         dvs_reg;
    logic                     out_valid_reg;

    frame_t                   frame_reg;
    sample_t                  held_l_reg, held_r_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    sample_t                  left_res_reg;
    sample_t                  left_out_reg, right_out_reg;
    logic                     blk_out_reg;

    logic [15:0]              jprod;
    logic [JM_W-1:0]          jmax;
    logic                     draw;
    logic                     div_step;
    logic                     div_done;
    logic [DIV_W:0]           rem_shift;
    logic [DIV_W-1:0]         rem_next;
    logic [SUM_W-1:0]         hold_sum;
    logic [HOLD_W-1:0]        hold_fin;
    logic                     load_out;

    logic [9:0]               wmix, dmix;
    logic signed [ACC_W-1:0]  mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MUL_W-1:0]  mul_p;

    assign jprod = 16'(cfg.jit) * 16'(cfg.rd);
    assign jmax  = JM_W'(jprod >> 9);

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign draw     = q_pop && (hold_reg == '0) && (jmax != '0);
    assign div_step = div_busy_reg && (div_cnt_reg != CNT_W'(DVD_W));
    assign div_done = div_busy_reg && (div_cnt_reg == CNT_W'(DVD_W));

    // One quotient bit per cycle; the remainder always stays below the divisor.
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_next  = (rem_shift >= {1'b0, dvs_reg}) ? DIV_W'(rem_shift - {1'b0, dvs_reg})
                                                      : DIV_W'(rem_shift);

    // New hold length is rd + rem - jmax, at least 1; the counter keeps it minus one.
    assign hold_sum = SUM_W'(cfg.rd) + SUM_W'(rem_reg);
    assign hold_fin = (hold_sum <= SUM_W'(jmax)) ? '0
                                                 : HOLD_W'(hold_sum - SUM_W'(jmax) - SUM_W'(1));

    assign load_out = (state_reg == ST_FIN) && !div_busy_reg
                      && (!out_valid_reg || !result_stall);

    assign wmix = {1'b0, cfg.mix};
    assign dmix = 10'd256 - wmix;

    always_comb
    begin
        unique case (state_reg)
            ST_L1:
            begin
                mul_a = ACC_W'(frame_reg.dry_l);
                mul_b = $signed(MB_W'(dmix));
            end
            ST_L2:
            begin
                mul_a = ACC_W'(held_l_reg);
                mul_b = $signed(MB_W'(wmix));
            end
            ST_R1:
            begin
                mul_a = ACC_W'(frame_reg.dry_r);
                mul_b = $signed(MB_W'(dmix));
            end
            ST_R2:
            begin
                mul_a = ACC_W'(held_r_reg);
                mul_b = $signed(MB_W'(wmix));
            end
            ST_L3, ST_R3:
            begin
                mul_a = acc_reg;
                mul_b = $signed(MB_W'(cfg.gain));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = q_valid ? ST_L1 : ST_IDLE;
            ST_L1:   state_next = ST_L2;
            ST_L2:   state_next = ST_L3;
            ST_L3:   state_next = ST_R1;
            ST_R1:   state_next = ST_R2;
            ST_R2:   state_next = ST_R3;
            ST_R3:   state_next = ST_FIN;
            ST_FIN:  state_next = load_out ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hold_reg      <= '0;
            rng_reg       <= RNG_SEED;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (q_pop)
            begin
                if (hold_reg != '0)
                begin
                    hold_reg <= hold_reg - HOLD_W'(1);
                end
                else if (jmax == '0)
                begin
                    hold_reg <= HOLD_W'(cfg.rd - 7'd1);
                end
            end
            else if (div_done)
            begin
                hold_reg <= hold_fin;
            end

            if (draw)
            begin
                rng_reg      <= xorshift(rng_reg);
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_step)
            begin
                div_cnt_reg <= div_cnt_reg + CNT_W'(1);
            end
            else if (div_done)
            begin
                div_busy_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (draw)
        begin
            dvd_reg <= xorshift(rng_reg);
            rem_reg <= '0;
            dvs_reg <= DIV_W'({jmax, 1'b1});
        end
        else if (div_step)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end

        if (q_pop)
        begin
            frame_reg <= q_rd_data;
            if (hold_reg == '0)
            begin
                held_l_reg <= q_rd_data.wet_l;
                held_r_reg <= q_rd_data.wet_r;
            end
        end

        case (state_reg)
            ST_L1, ST_R1:
            begin
                acc_reg <= ACC_W'(mul_p);
            end
            ST_L2, ST_R2:
            begin
                acc_reg <= acc_reg + ACC_W'(mul_p);
            end
            ST_L3, ST_R3:
            begin
                prod_reg <= PROD_W'(mul_p);
            end
            default:
            begin
            end
        endcase

        // The left product is still in place while the right channel starts.
        if (state_reg == ST_R1)
        begin
            left_res_reg <= round_sat(prod_reg);
        end

        if (load_out)
        begin
            left_out_reg  <= left_res_reg;
            right_out_reg <= round_sat(prod_reg);
            blk_out_reg   <= frame_reg.blk;
        end
    end

    assign result_valid  = out_valid_reg;
    assign left_out      = left_out_reg;
    assign right_out     = right_out_reg;
    assign block_end_out = blk_out_reg;

endmodule

@@ src/stereo_bitcrusher_decimator.sv @@
// Top level of the stereo bitcrusher and decimator: configuration registers and block wiring.
//
//  Channel | Signals                                   | Transfer at rising edge when
//  --------+-------------------------------------------+------------------------------------
//  frame   | frame_valid, frame_stall, left_in,        | frame_valid && !frame_stall
//          | right_in, block_end                       |
//  result  | result_valid, result_stall, left_out,     | result_valid && !result_stall
//          | right_out, block_end_out                  |
//  config  | cfg_we, cfg_index, cfg_data               | cfg_we
//
// A frame passes from the queue through the six steps of the shared 25x17 multiplier for mix
// and gain to the result register. A frame that reloads the hold counter with jitter also
// waits for the 32-step serial remainder of the random draw.
// Reset restores the register defaults, clears the hold counter and reseeds the generator.
// A two-frame queue takes input while the back end works, and the result register lets the
// next frame be processed while a result is stalled.
module stereo_bitcrusher_decimator #(
    parameter int MAX_DECIM = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sbcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbcd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              frame_valid,
    output logic                              frame_stall,
    input  sbcd_pkg::sample_t                 left_in,
    input  sbcd_pkg::sample_t                 right_in,
    input  logic                              block_end,
    output logic                              result_valid,
    input  logic                              result_stall,
    output sbcd_pkg::sample_t                 left_out,
    output sbcd_pkg::sample_t                 right_out,
    output logic                              block_end_out
);
    import sbcd_pkg::*;

    localparam int         RD_MAX = (MAX_DECIM > 127) ? 127 : MAX_DECIM;
    localparam logic [6:0] RD_LIM = 7'(RD_MAX);

    logic [4:0]  bit_depth_reg;
    logic [6:0]  decim_reg;
    logic [8:0]  jitter_amount_reg;
    logic [8:0]  mix_amount_reg;
    logic [14:0] output_gain_reg;

    cfg_t        cfg;
    logic        q_full;
    logic        q_push;
    frame_t      q_wr_data;
    logic        q_valid;
    logic        q_pop;
    frame_t      q_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg     <= RST_BIT_DEPTH;
            decim_reg         <= RST_DECIM;
            jitter_amount_reg <= RST_JITTER_AMOUNT;
            mix_amount_reg    <= RST_MIX_AMOUNT;
            output_gain_reg   <= RST_OUTPUT_GAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIT_DEPTH:     bit_depth_reg     <= cfg_data[4:0];
                REG_DECIM:         decim_reg         <= cfg_data[6:0];
                REG_JITTER_AMOUNT: jitter_amount_reg <= cfg_data[8:0];
                REG_MIX_AMOUNT:    mix_amount_reg    <= cfg_data[8:0];
                REG_OUTPUT_GAIN:   output_gain_reg   <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    // Out-of-range register values are limited here once for both ends.
    always_comb
    begin
        cfg.depth = (bit_depth_reg == 5'd0) ? 5'd1
                  : (bit_depth_reg > 5'(SAMPLE_W)) ? 5'(SAMPLE_W) : bit_depth_reg;
        cfg.rd    = (decim_reg == 7'd0) ? 7'd1
                  : (decim_reg > RD_LIM) ? RD_LIM : decim_reg;
        cfg.jit   = (jitter_amount_reg > 9'd256) ? 9'd256 : jitter_amount_reg;
        cfg.mix   = (mix_amount_reg > 9'd256) ? 9'd256 : mix_amount_reg;
        cfg.gain  = output_gain_reg;
    end

    sbcd_front u_front (
        .left_in     (left_in),
        .right_in    (right_in),
        .block_end   (block_end),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .depth       (cfg.depth),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wr_data   (q_wr_data)
    );

    sbcd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .q_valid (q_valid),
        .pop     (q_pop),
        .rd_data (q_rd_data)
    );

    sbcd_back #(
        .MAX_DECIM (MAX_DECIM)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_rd_data     (q_rd_data),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .block_end_out (block_end_out)
    );

endmodule

@@ bench/tb_stereo_bitcrusher_decimator.sv @@
// Self-checking testbench for the stereo bitcrusher and decimator, with a built-in predictor.
module tb_stereo_bitcrusher_decimator;
    timeunit 1ns;
    timeprecision 1ps;

    import sbcd_pkg::*;

    localparam int DECIM_MAX      = 64;
    localparam int PHASES         = 8;
    localparam int PHASE_FRAMES   = 94;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int CFG_SLOTS      = 1 << CFG_IDX_W;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    blk;
    } crushed_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        sample_t               left;
        sample_t               right;
        logic                  blk;
        bit                    typed;
        sample_t               want_left;
        sample_t               want_right;
    } plan_row_t;

    typedef enum {FLOW, COIN, HEAVY, PERIODIC} stall_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  frame_valid = 1'b0;
    logic                  frame_stall;
    sample_t               left_in = '0;
    sample_t               right_in = '0;
    logic                  block_end = 1'b0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    sample_t               left_out;
    sample_t               right_out;
    logic                  block_end_out;

    // Predictor copy of the registers and the hold state.
    logic [4:0]  reg_depth;
    logic [6:0]  reg_decim;
    logic [8:0]  reg_jitter;
    logic [8:0]  reg_mix;
    logic [14:0] reg_gain;
    logic [6:0]  frames_to_hold;
    sample_t     held_left;
    sample_t     held_right;
    logic [31:0] noise_state;

    crushed_t pending_out[$];
    int       errors = 0;
    int       results_seen = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    bit       squeeze = 1'b0;

    stereo_bitcrusher_decimator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .frame_valid   (frame_valid),
        .frame_stall   (frame_stall),
        .left_in       (left_in),
        .right_in      (right_in),
        .block_end     (block_end),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .left_out      (left_out),
        .right_out     (right_out),
        .block_end_out (block_end_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at result %0d: %s", results_seen, what);
        errors++;
    endtask

    function automatic sample_t clip_sample(input longint v);
        if (v > longint'(POS_MAX))
            return POS_MAX;
        if (v < longint'(NEG_MIN))
            return NEG_MIN;
        return sample_t'(v);
    endfunction

    // Round the magnitude to a multiple of the step, halves away from zero.
    function automatic sample_t quantize_to_depth(input sample_t x, input int depth);
        int     sh;
        longint mag;
        longint r;
        if (depth >= SAMPLE_W)
            return x;
        sh = SAMPLE_W - depth;
        mag = (x < 0) ? -longint'(x) : longint'(x);
        r = ((mag + (longint'(1) << (sh - 1))) >> sh) << sh;
        return clip_sample((x < 0) ? -r : r);
    endfunction

    function automatic sample_t mix_with_gain(input sample_t dry, input sample_t wet, input int mx);
        longint acc;
        longint mag;
        longint q;
        acc = longint'(dry) * longint'(256 - mx) + longint'(wet) * longint'(mx);
        mag = (acc < 0) ? -acc : acc;
        q = (mag * longint'(reg_gain) + (longint'(1) << 19)) >> 20;
        return clip_sample((acc < 0) ? -q : q);
    endfunction

    function automatic crushed_t predict_crush(input sample_t l, input sample_t r,
                                               input logic blk);
        int       depth;
        int       rd;
        int       jit;
        int       mx;
        int       jmax;
        int       next_hold;
        crushed_t res;
        depth = (reg_depth < 1) ? 1 : ((reg_depth > 16) ? 16 : int'(reg_depth));
        rd = (reg_decim < 1) ? 1 : ((reg_decim > DECIM_MAX) ? DECIM_MAX : int'(reg_decim));
        jit = (reg_jitter > 256) ? 256 : int'(reg_jitter);
        mx = (reg_mix > 256) ? 256 : int'(reg_mix);
        jmax = (jit * rd) >> 9;
        if (frames_to_hold == 0)
        begin
            held_left = quantize_to_depth(l, depth);
            held_right = quantize_to_depth(r, depth);
            next_hold = rd;
            if (jmax > 0)
            begin
                noise_state = noise_state ^ (noise_state << 13);
                noise_state = noise_state ^ (noise_state >> 17);
                noise_state = noise_state ^ (noise_state << 5);
                next_hold = rd + int'(noise_state % 32'(2 * jmax + 1)) - jmax;
                if (next_hold < 1)
                    next_hold = 1;
            end
            frames_to_hold = 7'(next_hold);
        end
        res.left = mix_with_gain(l, held_left, mx);
        res.right = mix_with_gain(r, held_right, mx);
        res.blk = blk;
        frames_to_hold = frames_to_hold - 7'd1;
        return res;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic plan_row_t frame_row(input sample_t l, input sample_t r, input logic blk,
                                            input bit typed = 1'b0,
                                            input sample_t wl = '0, input sample_t wr = '0);
        plan_row_t row;
        row = '{default: '0};
        row.left = l;
        row.right = r;
        row.blk = blk;
        row.typed = typed;
        row.want_left = wl;
        row.want_right = wr;
        return row;
    endfunction

    function automatic sample_t random_sample();
        logic [15:0] v;
        int          k;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = POS_MAX;
                    1: v = NEG_MIN;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            1: v = 16'($urandom_range(0, 600) - 300);
            2:
            begin
                // Exactly half a quantizer step above a multiple of the step.
                k = $urandom_range(0, 14);
                v = (v & ~((16'd1 << (k + 1)) - 16'd1)) | (16'd1 << k);
            end
            default: ;
        endcase
        return sample_t'(v);
    endfunction

    // Junk above the register's width must be ignored by the block.
    function automatic logic [CFG_DATA_W-1:0] reg_value(input int pick_rule, input int lo,
                                                        input int hi, input int width);
        logic [CFG_DATA_W-1:0] v;
        logic [CFG_DATA_W-1:0] junk;
        int                    pick;
        pick = (pick_rule < 2) ? pick_rule : $urandom_range(0, 5);
        case (pick)
            0: v = CFG_DATA_W'(lo);
            1: v = CFG_DATA_W'(hi);
            2: v = CFG_DATA_W'($urandom_range(0, (1 << width) - 1));
            default: v = CFG_DATA_W'($urandom_range(lo, hi));
        endcase
        junk = CFG_DATA_W'($urandom);
        return v | (junk & ({CFG_DATA_W{1'b1}} << width));
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_BIT_DEPTH:     reg_depth = data[4:0];
            REG_DECIM:         reg_decim = data[6:0];
            REG_JITTER_AMOUNT: reg_jitter = data[8:0];
            REG_MIX_AMOUNT:    reg_mix = data[8:0];
            REG_OUTPUT_GAIN:   reg_gain = data[14:0];
            default: ;
        endcase
    endtask

    task automatic wait_until_drained();
        if (frame_valid)
            frame_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_frame(input sample_t l, input sample_t r, input logic blk,
                              input bit typed = 1'b0,
                              input sample_t wl = '0, input sample_t wr = '0);
        int       gap;
        crushed_t exp_out;
        if (cfg_we)
            cfg_we <= 1'b0;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
                0: gap = 0;
                1: gap = $urandom_range(20, 45);
                default: gap = $urandom_range(1, 10);
            endcase
        end
        burst_left--;
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        left_in <= l;
        right_in <= r;
        block_end <= blk;
        do
            @(posedge clk);
        while (frame_stall);
        exp_out = predict_crush(l, r, blk);
        if (typed)
        begin
            exp_out.left = wl;
            exp_out.right = wr;
        end
        pending_out = {pending_out, exp_out};
    endtask

    initial
    begin : stimulus
        plan_row_t plan[$];
        int        phase;
        int        n;

        reg_depth = RST_BIT_DEPTH;
        reg_decim = RST_DECIM;
        reg_jitter = RST_JITTER_AMOUNT;
        reg_mix = RST_MIX_AMOUNT;
        reg_gain = RST_OUTPUT_GAIN;
        frames_to_hold = '0;
        held_left = '0;
        held_right = '0;
        noise_state = RNG_SEED;

        // Reset settings: the first frame is latched and held for the next seven.
        plan = {plan, frame_row(POS_MAX, NEG_MIN, 1'b1, 1'b1, POS_MAX, NEG_MIN)};
        plan = {plan, frame_row(NEG_MIN, POS_MAX, 1'b0, 1'b1, POS_MAX, NEG_MIN)};
        plan = {plan, frame_row(0, 0, 1'b1, 1'b1, POS_MAX, NEG_MIN)};
        plan = {plan, frame_row(-1, -1, 1'b0, 1'b1, POS_MAX, NEG_MIN)};
        plan = {plan, frame_row(21845, -21846, 1'b1, 1'b1, POS_MAX, NEG_MIN)};
        plan = {plan, frame_row(-21846, 21845, 1'b0, 1'b1, POS_MAX, NEG_MIN)};
        plan = {plan, frame_row(1, -1, 1'b1, 1'b1, POS_MAX, NEG_MIN)};
        plan = {plan, frame_row(POS_MAX, POS_MAX, 1'b0, 1'b1, POS_MAX, NEG_MIN)};
        // Sample every frame; full depth passes the input through.
        plan = {plan, cfg_row(REG_DECIM, 1)};
        plan = {plan, cfg_row(REG_BIT_DEPTH, 16)};
        plan = {plan, frame_row(NEG_MIN, POS_MAX, 1'b0, 1'b1, NEG_MIN, POS_MAX)};
        plan = {plan, frame_row(12345, -12345, 1'b1, 1'b1, 12345, -12345)};
        // One bit: half scale rounds up and saturates, just below rounds to zero.
        plan = {plan, cfg_row(REG_BIT_DEPTH, 1)};
        plan = {plan, frame_row(16384, -16384, 1'b0, 1'b1, POS_MAX, NEG_MIN)};
        plan = {plan, frame_row(16383, -16383, 1'b1, 1'b1, 0, 0)};
        plan = {plan, cfg_row(REG_BIT_DEPTH, 8)};
        plan = {plan, frame_row(128, -128, 1'b0, 1'b1, 256, -256)};
        plan = {plan, frame_row(127, -127, 1'b1, 1'b1, 0, 0)};
        // Fully dry, then zero gain, then maximum gain.
        plan = {plan, cfg_row(REG_MIX_AMOUNT, 0)};
        plan = {plan, frame_row(NEG_MIN, 777, 1'b0, 1'b1, NEG_MIN, 777)};
        plan = {plan, cfg_row(REG_OUTPUT_GAIN, 0)};
        plan = {plan, frame_row(POS_MAX, NEG_MIN, 1'b1, 1'b1, 0, 0)};
        plan = {plan, cfg_row(REG_OUTPUT_GAIN, 32767)};
        plan = {plan, frame_row(POS_MAX, NEG_MIN, 1'b0, 1'b1, POS_MAX, NEG_MIN)};
        plan = {plan, frame_row(1000, -3, 1'b1)};
        plan = {plan, cfg_row(REG_MIX_AMOUNT, 128)};
        plan = {plan, frame_row(-20000, 9999, 1'b0)};
        // Longest hold with full jitter.
        plan = {plan, cfg_row(REG_OUTPUT_GAIN, 4096)};
        plan = {plan, cfg_row(REG_DECIM, 64)};
        plan = {plan, cfg_row(REG_JITTER_AMOUNT, 256)};
        plan = {plan, frame_row(3000, -3000, 1'b1)};
        plan = {plan, frame_row(-5, 5, 1'b0)};
        plan = {plan, frame_row(POS_MAX, NEG_MIN, 1'b1)};
        // Out-of-range register values are limited by the block.
        plan = {plan, cfg_row(REG_BIT_DEPTH, 0)};
        plan = {plan, cfg_row(REG_DECIM, 0)};
        plan = {plan, cfg_row(REG_JITTER_AMOUNT, 511)};
        plan = {plan, cfg_row(REG_MIX_AMOUNT, 511)};
        plan = {plan, frame_row(16384, -8192, 1'b0)};
        plan = {plan, cfg_row(REG_BIT_DEPTH, 31)};
        plan = {plan, cfg_row(REG_DECIM, 127)};
        plan = {plan, frame_row(-12345, 4321, 1'b1)};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_until_drained();
                cfg_write(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_frame(plan[i].left, plan[i].right, plan[i].blk, plan[i].typed,
                           plan[i].want_left, plan[i].want_right);
            end
        end

        // First phase takes all low limits, the second all high limits.
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_until_drained();
            cfg_write(REG_BIT_DEPTH, reg_value(phase, 1, 16, 5));
            cfg_write(REG_DECIM, reg_value(phase, 1, DECIM_MAX, 7));
            cfg_write(REG_JITTER_AMOUNT, reg_value(phase, 0, 256, 9));
            cfg_write(REG_MIX_AMOUNT, reg_value(phase, 0, 256, 9));
            cfg_write(REG_OUTPUT_GAIN, reg_value(phase, 0, 32767, 15));
            cfg_write(CFG_IDX_W'($urandom_range(int'(REG_OUTPUT_GAIN) + 1, CFG_SLOTS - 1)),
                      CFG_DATA_W'($urandom));
            for (n = 0; n < PHASE_FRAMES; n++)
            begin
                if (phase == 1 && n == 30)
                    squeeze = 1'b1;
                send_frame(random_sample(), random_sample(), 1'($urandom_range(0, 1)));
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : receiver
        stall_mode_t mode;
        int          mode_left;
        int          beat;
        bit          squeezed;
        mode = FLOW;
        mode_left = 0;
        beat = 0;
        squeezed = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // Hold results back long enough for the input queue to fill.
            if (squeeze && !squeezed)
            begin
                squeezed = 1'b1;
                result_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            beat++;
            case (mode)
                FLOW:    result_stall <= 1'b0;
                COIN:    result_stall <= 1'($urandom_range(0, 1));
                HEAVY:   result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= ((beat % 5) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        crushed_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (pending_out.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = pending_out.pop_front();
                    if (left_out !== want.left)
                        report_mismatch($sformatf("left_out %0d, expected %0d",
                                                  left_out, want.left));
                    if (right_out !== want.right)
                        report_mismatch($sformatf("right_out %0d, expected %0d",
                                                  right_out, want.right));
                    if (block_end_out !== want.blk)
                        report_mismatch($sformatf("block_end_out %b, expected %b",
                                                  block_end_out, want.blk));
                end
            end
            if ((frame_valid && !frame_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TIMEOUT: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
